FILE: rtl/core/gtc_pkg.sv
`default_nettype none

package gtc_pkg;

    // configuration
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_TARGET    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BIAS      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_SPEED = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SPEED = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_RATE  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT   = 3'd6;

    // field widths
    localparam int RAW_W   = 10;
    localparam int BIAS_W  = 14;
    localparam int MRATE_W = 10;
    localparam int RATE_W  = 13;

    // shared multiplier
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 23;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // rate conditioning
    localparam logic [13:0]        RATE_LIM_MAX = 14'd4095;
    localparam logic signed [15:0] DEADBAND_Q4  = 16'sd3;

    // divide by 125 through reciprocal, valid for dividends below 2**22
    localparam logic [15:0] RECIP_125   = 16'd33554;
    localparam int          RECIP_SHIFT = 22;
    localparam logic [6:0]  DIV_125     = 7'd125;

    localparam logic [15:0] UNITS_PER_DEG   = 16'd32000;
    localparam logic [39:0] ANGLE_SAT_UNITS = 40'd65536000;
    localparam logic signed [40:0] DONE_UNITS = 41'sd96000;
    localparam logic [16:0] ELAPSED_MAX = 17'd131071;
    localparam logic signed [7:0] PRELOAD = 8'sd5;

endpackage

`default_nettype wire

FILE: rtl/core/gtc_rate.sv
`default_nettype none

module gtc_rate (
    input  wire logic [gtc_pkg::RAW_W-1:0]          i_gyro_raw,
    input  wire logic [gtc_pkg::BIAS_W-1:0]         i_bias,
    input  wire logic [gtc_pkg::MRATE_W-1:0]        i_max_rate,
    output logic signed [gtc_pkg::RATE_W-1:0]       o_rate
);

    logic signed [15:0] w_diff;
    logic [13:0]        w_lim_full;
    logic [11:0]        w_lim;
    logic signed [15:0] w_lim_s;
    logic signed [15:0] w_clamp;

    assign w_diff = $signed({2'b00, i_bias}) - $signed({2'b00, i_gyro_raw, 4'b0000});
    assign w_lim_full = {i_max_rate, 4'b0000};
    assign w_lim = (w_lim_full > gtc_pkg::RATE_LIM_MAX) ? gtc_pkg::RATE_LIM_MAX[11:0]
                                                         : w_lim_full[11:0];
    assign w_lim_s = $signed({4'b0000, w_lim});

    always_comb begin
        if (w_diff > w_lim_s) begin
            w_clamp = w_lim_s;
        end else if (w_diff < -w_lim_s) begin
            w_clamp = -w_lim_s;
        end else begin
            w_clamp = w_diff;
        end
    end

    // deadband around zero
    assign o_rate = ((w_clamp >= -gtc_pkg::DEADBAND_Q4) && (w_clamp <= gtc_pkg::DEADBAND_Q4))
                    ? '0 : w_clamp[gtc_pkg::RATE_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/gtc_mul.sv
`default_nettype none

module gtc_mul (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic signed [gtc_pkg::MUL_A_W-1:0]   i_a,
    input  wire logic signed [gtc_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [gtc_pkg::PROD_W-1:0]         o_prod
);

    logic signed [gtc_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

FILE: rtl/core/gyro_turn_controller_top.sv
`default_nettype none

// gyro turn controller
// input stream: s_axis_tuser is the opcode (0 start turn, 1 gyro sample),
// s_axis_tdata carries the gyro reading and the sample interval in ms.
// output stream: one result per request with both motor drives, the
// integrated angle in 1/16 degree and the done / timed-out flags.
// configuration: i_cfg_we writes register i_cfg_addr with i_cfg_wdata
// (0 target, 1 bias, 2 gain, 3 max speed, 4 min speed, 5 max rate,
// 6 timeout); other addresses are dropped. write only while idle.
// a start request, or a sample after the turn has finished, goes from idle
// straight to the output state; an active sample steps through the rate,
// multiply, accumulate, angle and decision states and, unless the turn ends
// on it, the speed states. all multiplies of a sample, including the two
// reciprocal divides by 125, run one after another on a single shared
// multiplier, so one request is in work at a time and s_axis_tready is low
// meanwhile. a new request is taken while the last result still waits.
// reset clears the angle, rate and elapsed time, loads the register
// defaults and leaves the turn finished until a start request.
// when m_axis_tready is low the result is held and the sequencer waits
// with its next result before it loads the output register.

module gyro_turn_controller_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // gyro_raw[9:0], delta_ms[19:10]
    input  wire logic        s_axis_tuser,   // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // left_drive[7:0], right_drive[15:8], angle_q4[31:16]
    output logic [1:0]       m_axis_tuser,   // turn_done[0], timed_out[1]
    input  wire logic                            i_cfg_we,
    input  wire logic [gtc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [gtc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RATE = 4'd1;
    localparam logic [3:0] ST_MULD = 4'd2;
    localparam logic [3:0] ST_ACC  = 4'd3;
    localparam logic [3:0] ST_ABS  = 4'd4;
    localparam logic [3:0] ST_REM  = 4'd5;
    localparam logic [3:0] ST_AQ1  = 4'd6;
    localparam logic [3:0] ST_AQ2  = 4'd7;
    localparam logic [3:0] ST_AQ3  = 4'd8;
    localparam logic [3:0] ST_DEC  = 4'd9;
    localparam logic [3:0] ST_SP1  = 4'd10;
    localparam logic [3:0] ST_SP2  = 4'd11;
    localparam logic [3:0] ST_SP3  = 4'd12;
    localparam logic [3:0] ST_SP4  = 4'd13;
    localparam logic [3:0] ST_OUT  = 4'd14;

    typedef struct packed {
        logic signed [7:0] left;
        logic signed [7:0] right;
        logic              done;
        logic              to;
    } t_result;

    // configuration registers
    logic signed [10:0]                 r_target;
    logic [gtc_pkg::BIAS_W-1:0]         r_bias;
    logic [7:0]                         r_gain;
    logic [6:0]                         r_max_speed;
    logic [6:0]                         r_min_speed;
    logic [gtc_pkg::MRATE_W-1:0]        r_max_rate;
    logic [15:0]                        r_timeout;

    // turn state
    logic signed [39:0]                 r_acc;
    logic signed [gtc_pkg::RATE_W-1:0]  r_prev_rate;
    logic [16:0]                        r_elapsed;
    logic                               r_finished;
    logic signed [15:0]                 r_angle_q4;

    // sequencer and working registers
    logic [3:0]                         r_state;
    logic [3:0]                         n_state;
    logic [gtc_pkg::RAW_W-1:0]          r_raw;
    logic [9:0]                         r_dt;
    logic signed [gtc_pkg::RATE_W-1:0]  r_rate;
    logic [39:0]                        r_abs;
    logic                               r_neg;
    logic                               r_angle_sat;
    logic signed [40:0]                 r_rem;
    logic [21:0]                        r_x;
    logic [14:0]                        r_q;
    t_result                            r_pend;

    // output register
    logic                               r_out_valid;
    t_result                            r_out;
    logic signed [15:0]                 r_out_angle;

    logic                               w_in_acc;
    logic                               w_load;
    logic                               w_tgt_neg;
    logic [10:0]                        w_abs_t;
    logic signed [gtc_pkg::RATE_W-1:0]  w_rate;
    logic signed [13:0]                 w_rate_sum;
    logic [17:0]                        w_elapsed_sum;
    logic signed [40:0]                 w_acc_sum;
    logic signed [40:0]                 w_rem;
    logic [21:0]                        w_div_rem;
    logic [14:0]                        w_q_fix;
    logic [6:0]                         w_spd_cap;
    logic [6:0]                         w_spd;
    logic signed [7:0]                  w_spd_pos;
    logic signed [7:0]                  w_spd_neg;
    logic                               w_mul_en;
    logic signed [gtc_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [gtc_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [gtc_pkg::PROD_W-1:0]  w_prod;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_load        = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);

    assign w_tgt_neg = r_target[10];
    assign w_abs_t   = w_tgt_neg ? 11'(-r_target) : r_target;

    gtc_rate u_rate (
        .i_gyro_raw (r_raw),
        .i_bias     (r_bias),
        .i_max_rate (r_max_rate),
        .o_rate     (w_rate)
    );

    gtc_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_rate_sum    = 14'(r_rate) + 14'(r_prev_rate);
    assign w_elapsed_sum = {1'b0, r_elapsed} + {8'b0, r_dt};
    assign w_acc_sum     = {r_acc[39], r_acc} + w_prod[40:0];
    assign w_rem         = $signed({15'b0, w_prod[25:0]}) - $signed({1'b0, r_abs});

    // correction step of the reciprocal divide
    assign w_div_rem = r_x - w_prod[21:0];
    assign w_q_fix   = r_q + {14'b0, (w_div_rem >= {15'b0, gtc_pkg::DIV_125})};

    assign w_spd_cap = (w_q_fix > {8'b0, r_max_speed}) ? r_max_speed : w_q_fix[6:0];
    assign w_spd     = (w_spd_cap < r_min_speed) ? r_min_speed : w_spd_cap;
    assign w_spd_pos = $signed({1'b0, w_spd});
    assign w_spd_neg = -w_spd_pos;

    // shared multiplier operand select
    always_comb begin
        w_mul_en = 1'b1;
        w_mul_a  = '0;
        w_mul_b  = '0;
        case (r_state)
            ST_MULD: begin
                w_mul_a = 27'(w_rate_sum);
                w_mul_b = $signed({13'b0, r_dt});
            end
            ST_ACC: begin
                w_mul_a = $signed({16'b0, w_abs_t});
                w_mul_b = $signed({7'b0, gtc_pkg::UNITS_PER_DEG});
            end
            ST_REM: begin
                w_mul_a = $signed({5'b0, r_abs[25:4]});
                w_mul_b = $signed({7'b0, gtc_pkg::RECIP_125});
            end
            ST_AQ2, ST_SP3: begin
                w_mul_a = $signed({12'b0, r_q});
                w_mul_b = $signed({16'b0, gtc_pkg::DIV_125});
            end
            ST_DEC: begin
                w_mul_a = $signed({1'b0, r_rem[25:0]});
                w_mul_b = $signed({15'b0, r_gain});
            end
            ST_SP1: begin
                w_mul_a = $signed({6'b0, w_prod[32:12]});
                w_mul_b = $signed({7'b0, gtc_pkg::RECIP_125});
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser && !r_finished) begin
                        n_state = ST_RATE;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_RATE: n_state = ST_MULD;
            ST_MULD: n_state = ST_ACC;
            ST_ACC:  n_state = ST_ABS;
            ST_ABS:  n_state = ST_REM;
            ST_REM:  n_state = ST_AQ1;
            ST_AQ1:  n_state = ST_AQ2;
            ST_AQ2:  n_state = ST_AQ3;
            ST_AQ3:  n_state = ST_DEC;
            ST_DEC: begin
                if ((r_elapsed >= {1'b0, r_timeout}) || (r_rem <= gtc_pkg::DONE_UNITS)) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_SP1;
                end
            end
            ST_SP1:  n_state = ST_SP2;
            ST_SP2:  n_state = ST_SP3;
            ST_SP3:  n_state = ST_SP4;
            ST_SP4:  n_state = ST_OUT;
            ST_OUT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= 11'sd90;
            r_bias      <= 14'd9600;
            r_gain      <= 8'd80;
            r_max_speed <= 7'd85;
            r_min_speed <= 7'd40;
            r_max_rate  <= 10'd180;
            r_timeout   <= 16'd5100;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                gtc_pkg::REG_TARGET:    r_target    <= i_cfg_wdata[10:0];
                gtc_pkg::REG_BIAS:      r_bias      <= i_cfg_wdata[gtc_pkg::BIAS_W-1:0];
                gtc_pkg::REG_GAIN:      r_gain      <= i_cfg_wdata[7:0];
                gtc_pkg::REG_MAX_SPEED: r_max_speed <= i_cfg_wdata[6:0];
                gtc_pkg::REG_MIN_SPEED: r_min_speed <= i_cfg_wdata[6:0];
                gtc_pkg::REG_MAX_RATE:  r_max_rate  <= i_cfg_wdata[gtc_pkg::MRATE_W-1:0];
                gtc_pkg::REG_TIMEOUT:   r_timeout   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // turn state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_prev_rate <= '0;
            r_elapsed   <= '0;
            r_finished  <= 1'b1;
            r_angle_q4  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && !s_axis_tuser) begin
                        r_acc       <= '0;
                        r_prev_rate <= '0;
                        r_elapsed   <= '0;
                        r_angle_q4  <= '0;
                        r_finished  <= (w_abs_t <= 11'd3);
                    end
                end
                ST_MULD: begin
                    r_prev_rate <= r_rate;
                    r_elapsed   <= w_elapsed_sum[17] ? gtc_pkg::ELAPSED_MAX
                                                     : w_elapsed_sum[16:0];
                end
                ST_ACC: begin
                    if (w_acc_sum[40] != w_acc_sum[39]) begin
                        r_acc <= w_acc_sum[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
                    end else begin
                        r_acc <= w_acc_sum[39:0];
                    end
                end
                ST_AQ3: begin
                    if (r_angle_sat) begin
                        r_angle_q4 <= r_neg ? 16'sh8000 : 16'sh7fff;
                    end else begin
                        r_angle_q4 <= r_neg ? -$signed({1'b0, w_q_fix})
                                            : $signed({1'b0, w_q_fix});
                    end
                end
                ST_DEC: begin
                    if ((r_elapsed >= {1'b0, r_timeout}) || (r_rem <= gtc_pkg::DONE_UNITS)) begin
                        r_finished <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_raw <= s_axis_tdata[9:0];
                r_dt  <= (s_axis_tdata[19:10] == 10'd0) ? 10'd1 : s_axis_tdata[19:10];
                if (!s_axis_tuser) begin
                    if (w_abs_t <= 11'd3) begin
                        r_pend <= '{left: '0, right: '0, done: 1'b1, to: 1'b0};
                    end else begin
                        r_pend <= '{left:  w_tgt_neg ? gtc_pkg::PRELOAD : -gtc_pkg::PRELOAD,
                                    right: w_tgt_neg ? -gtc_pkg::PRELOAD : gtc_pkg::PRELOAD,
                                    done: 1'b0, to: 1'b0};
                    end
                end else begin
                    r_pend <= '{left: '0, right: '0, done: 1'b1, to: 1'b0};
                end
            end
            ST_RATE: r_rate <= w_rate;
            ST_ABS: begin
                r_abs <= r_acc[39] ? 40'(-r_acc) : r_acc;
                r_neg <= r_acc[39];
            end
            ST_REM: begin
                r_rem       <= w_rem;
                r_x         <= r_abs[25:4];
                r_angle_sat <= (r_abs >= gtc_pkg::ANGLE_SAT_UNITS);
            end
            ST_AQ1, ST_SP2: r_q <= w_prod[gtc_pkg::RECIP_SHIFT+14:gtc_pkg::RECIP_SHIFT];
            ST_DEC: begin
                if (r_elapsed >= {1'b0, r_timeout}) begin
                    r_pend <= '{left: '0, right: '0, done: 1'b1, to: 1'b1};
                end else begin
                    r_pend <= '{left: '0, right: '0, done: 1'b1, to: 1'b0};
                end
            end
            ST_SP1: r_x <= {1'b0, w_prod[32:12]};
            ST_SP4: begin
                r_pend <= '{left:  w_tgt_neg ? w_spd_neg : w_spd_pos,
                            right: w_tgt_neg ? w_spd_pos : w_spd_neg,
                            done: 1'b0, to: 1'b0};
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out       <= r_pend;
            r_out_angle <= r_angle_q4;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_angle, r_out.right, r_out.left};
    assign m_axis_tuser  = {r_out.to, r_out.done};

`ifndef SYNTH
    a_done_zero_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[15:0] == 16'd0))
        else $error("finished result with nonzero drive");

    a_timeout_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
        else $error("timeout result without done flag");

    a_div_correction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_AQ3) || (r_state == ST_SP4)) |->
        (w_div_rem < {14'b0, gtc_pkg::DIV_125, 1'b0}))
        else $error("reciprocal divide off by more than one");

    a_rate_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |-> (r_prev_rate != {1'b1, {(gtc_pkg::RATE_W-1){1'b0}}}))
        else $error("stored rate outside clamp range");
`endif

endmodule

`default_nettype wire
